// File: sv/oectmr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oectmr_pkg
// Shared types and constants of the overflow-extended countdown timer bank.
// ----------------------------------------------------------------------------
package oectmr_pkg;

   localparam int CMD_WIDTH   = 3;
   localparam int INDEX_WIDTH = 4;
   localparam int VALUE_WIDTH = 32;
   localparam int LOOP_WIDTH  = 16;
   localparam int CNT_WIDTH   = 8;
   localparam int CSR_WIDTH   = 16;

   localparam logic [CNT_WIDTH-1:0] CNT_TOP = 8'hff;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_COUNT   = 3'd0,
      CMD_LOAD    = 3'd1,
      CMD_START   = 3'd2,
      CMD_STOP    = 3'd3,
      CMD_CLEAR   = 3'd4,
      CMD_READ    = 3'd5,
      CMD_RESTART = 3'd6,
      CMD_RSVD    = 3'd7
   } cmd_type;

   typedef enum logic {
      CSR_LOOP_COUNT      = 1'b0,
      CSR_REMAINDER_COUNT = 1'b1
   } csr_index_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SWEEP,
      S_DRAIN,
      S_LOOKUP,
      S_EXEC
   } state_type;

endpackage : oectmr_pkg
`default_nettype wire

// File: sv/oectmr_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// oectmr_req_if / oectmr_rsp_if
// Valid/ready channels for command items and status result items.
// ----------------------------------------------------------------------------
interface oectmr_req_if;
   logic                                    valid;
   logic                                    ready;
   logic [oectmr_pkg::CMD_WIDTH-1:0]        cmd;
   logic [oectmr_pkg::INDEX_WIDTH-1:0]      timer_index;
   logic [oectmr_pkg::VALUE_WIDTH-1:0]      load_value;

   modport source (output valid, cmd, timer_index, load_value, input ready);
   modport sink   (input valid, cmd, timer_index, load_value, output ready);
endinterface : oectmr_req_if

interface oectmr_rsp_if;
   logic                                    valid;
   logic                                    ready;
   logic                                    tick_fired;
   logic [oectmr_pkg::INDEX_WIDTH-1:0]      slot_index;
   logic [oectmr_pkg::VALUE_WIDTH-1:0]      ticks_left;
   logic                                    slot_running;
   logic                                    slot_finished;

   modport source (output valid, tick_fired, slot_index, ticks_left, slot_running,
                   slot_finished, input ready);
   modport sink   (input valid, tick_fired, slot_index, ticks_left, slot_running,
                   slot_finished, output ready);
endinterface : oectmr_rsp_if
`default_nettype wire

// File: sv/overflow_extended_countdown_timers_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// overflow_extended_countdown_timers_core
// Prescaled overflow counter driving a bank of countdown timers held in RAM.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan carries one command item (count pulse, load, start, stop, clear,
//   read, restart period); rsp_chan returns exactly one status item per
//   command, reporting the addressed slot after the command took effect.
//   csr_we/csr_index/csr_wdata write loop_count and remainder_count; write
//   them only while the block is idle.
// Timing:
//   a command passes through the lookup and execute states before its result
//   is registered, and the next item is taken once the block is idle again. A
//   count pulse that fires a base tick first sweeps the slot RAM, one entry per
//   cycle through its single read and single write port, and then drains.
// Reset:
//   synchronous; clears the prescaler, config, state and valid flags and the
//   per-slot valid bits, so every slot reads zero until written; no clear pass.
// Stall:
//   a result waits in the output register while the next item is accepted;
//   that item then holds in its final step until the result is taken.
// ----------------------------------------------------------------------------
module overflow_extended_countdown_timers_core #(
   parameter int NUM_TIMERS = 16,
   parameter int TICK_WIDTH = 32
) (
   input  wire                                  clock,
   input  wire                                  reset,
   oectmr_req_if.sink                           req_chan,
   oectmr_rsp_if.source                         rsp_chan,
   input  wire                                  csr_we,
   input  wire                                  csr_index,
   input  wire [oectmr_pkg::CSR_WIDTH-1:0]      csr_wdata
);

   localparam int AW      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
   localparam int EW      = TICK_WIDTH + 2;
   localparam int RUN_BIT = EW - 1;
   localparam int FIN_BIT = EW - 2;
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_TIMERS - 1);

   // configuration
   logic [oectmr_pkg::LOOP_WIDTH-1:0] loop_ff;
   logic [oectmr_pkg::CNT_WIDTH-1:0]  rem_ff;

   // prescaler
   logic [oectmr_pkg::CNT_WIDTH-1:0]  cnt_ff, cnt_in;
   logic [oectmr_pkg::LOOP_WIDTH-1:0] ovf_ff, ovf_in;
   logic                              inrem_ff, inrem_in;
   logic                              fire;

   // sequencer
   oectmr_pkg::state_type             state_ff, state_in;
   oectmr_pkg::cmd_type               cmd_ff, cmd_in;
   logic [oectmr_pkg::INDEX_WIDTH-1:0] idx_ff, idx_in;
   logic [TICK_WIDTH-1:0]             val_ff, val_in;
   logic                              fired_ff, fired_in;
   logic [AW-1:0]                     ptr_ff, ptr_in;
   logic                              wr_pend_ff, wr_pend_in;
   logic [AW-1:0]                     wr_addr_ff, wr_addr_in;

   // slot memory
   logic [EW-1:0]                     mem [NUM_TIMERS];
   logic [NUM_TIMERS-1:0]             vld_ff;
   logic [EW-1:0]                     rd_data_ff;
   logic                              rd_vld_ff;
   logic                              mem_re, mem_we;
   logic [AW-1:0]                     mem_ra, mem_wa;
   logic [EW-1:0]                     mem_wd;
   logic [EW-1:0]                     cur, sweep_wd, exec_wd;
   logic [TICK_WIDTH-1:0]             dec;
   logic                              idx_ok;
   logic [AW-1:0]                     idx_addr;
   logic                              done;

   // result register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_fired_ff, rsp_fired_in;
   logic [oectmr_pkg::INDEX_WIDTH-1:0] rsp_idx_ff, rsp_idx_in;
   logic [oectmr_pkg::VALUE_WIDTH-1:0] rsp_ticks_ff, rsp_ticks_in;
   logic                              rsp_run_ff, rsp_run_in;
   logic                              rsp_fin_ff, rsp_fin_in;

   assign req_chan.ready         = (state_ff == oectmr_pkg::S_IDLE);
   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.tick_fired    = rsp_fired_ff;
   assign rsp_chan.slot_index    = rsp_idx_ff;
   assign rsp_chan.ticks_left    = rsp_ticks_ff;
   assign rsp_chan.slot_running  = rsp_run_ff;
   assign rsp_chan.slot_finished = rsp_fin_ff;

   assign idx_ok   = (32'(idx_ff) < NUM_TIMERS);
   assign idx_addr = AW'(idx_ff);
   assign cur      = rd_vld_ff ? rd_data_ff : '0;
   assign dec      = cur[TICK_WIDTH-1:0] - TICK_WIDTH'(1);
   assign done     = !rsp_valid_ff || rsp_chan.ready;

   // base tick update of one entry
   always_comb begin
      sweep_wd = cur;
      if (cur[RUN_BIT]) begin
         sweep_wd[TICK_WIDTH-1:0] = dec;
         if (dec == '0) begin
            sweep_wd[RUN_BIT] = 1'b0;
            sweep_wd[FIN_BIT] = 1'b1;
         end
      end
   end

   // command update of the addressed entry
   always_comb begin
      exec_wd = cur;
      case (cmd_ff)
         oectmr_pkg::CMD_LOAD: begin
            exec_wd[TICK_WIDTH-1:0] = val_ff;
         end
         oectmr_pkg::CMD_START: begin
            exec_wd[RUN_BIT] = 1'b1;
            exec_wd[FIN_BIT] = 1'b0;
         end
         oectmr_pkg::CMD_STOP: begin
            exec_wd[RUN_BIT] = 1'b0;
         end
         oectmr_pkg::CMD_CLEAR: begin
            exec_wd = '0;
         end
         default: begin
            exec_wd = cur;
         end
      endcase
   end

   // prescaler next state for the item on the request channel
   always_comb begin
      logic [oectmr_pkg::CNT_WIDTH-1:0] p1;
      logic                             do_restart;
      p1         = cnt_ff + 8'd1;
      cnt_in     = cnt_ff;
      ovf_in     = ovf_ff;
      inrem_in   = inrem_ff;
      fire       = 1'b0;
      do_restart = 1'b0;
      case (oectmr_pkg::cmd_type'(req_chan.cmd))
         oectmr_pkg::CMD_COUNT: begin
            cnt_in = p1;
            if (p1 == '0) begin
               if (ovf_ff == loop_ff) begin
                  if (inrem_ff) begin
                     fire       = 1'b1;
                     do_restart = 1'b1;
                  end else begin
                     inrem_in = 1'b1;
                     cnt_in   = oectmr_pkg::CNT_TOP - rem_ff;
                  end
               end else begin
                  ovf_in = ovf_ff + 16'd1;
               end
            end
         end
         oectmr_pkg::CMD_RESTART: begin
            do_restart = 1'b1;
         end
         default: begin
            do_restart = 1'b0;
         end
      endcase
      if (do_restart) begin
         if (loop_ff != '0) begin
            ovf_in   = '0;
            inrem_in = 1'b0;
         end else begin
            inrem_in = 1'b1;
            cnt_in   = oectmr_pkg::CNT_TOP - rem_ff;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      idx_in       = idx_ff;
      val_in       = val_ff;
      fired_in     = fired_ff;
      ptr_in       = ptr_ff;
      wr_pend_in   = 1'b0;
      wr_addr_in   = wr_addr_ff;
      mem_re       = 1'b0;
      mem_ra       = ptr_ff;
      mem_we       = 1'b0;
      mem_wa       = wr_addr_ff;
      mem_wd       = sweep_wd;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_fired_in = rsp_fired_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_ticks_in = rsp_ticks_ff;
      rsp_run_in   = rsp_run_ff;
      rsp_fin_in   = rsp_fin_ff;
      unique case (state_ff)
         oectmr_pkg::S_IDLE: begin
            if (req_chan.valid) begin
               cmd_in   = oectmr_pkg::cmd_type'(req_chan.cmd);
               idx_in   = req_chan.timer_index;
               val_in   = TICK_WIDTH'(req_chan.load_value);
               fired_in = fire;
               ptr_in   = '0;
               state_in = fire ? oectmr_pkg::S_SWEEP : oectmr_pkg::S_LOOKUP;
            end
         end
         oectmr_pkg::S_SWEEP: begin
            // read entry ptr while writing back the one read last cycle
            mem_re     = 1'b1;
            mem_ra     = ptr_ff;
            mem_we     = wr_pend_ff;
            wr_pend_in = 1'b1;
            wr_addr_in = ptr_ff;
            if (ptr_ff == LAST_ADDR) begin
               state_in = oectmr_pkg::S_DRAIN;
            end else begin
               ptr_in = ptr_ff + AW'(1);
            end
         end
         oectmr_pkg::S_DRAIN: begin
            mem_we   = wr_pend_ff;
            state_in = oectmr_pkg::S_LOOKUP;
         end
         oectmr_pkg::S_LOOKUP: begin
            mem_re   = idx_ok;
            mem_ra   = idx_addr;
            state_in = oectmr_pkg::S_EXEC;
         end
         oectmr_pkg::S_EXEC: begin
            if (done) begin
               mem_we       = idx_ok;
               mem_wa       = idx_addr;
               mem_wd       = exec_wd;
               rsp_valid_in = 1'b1;
               rsp_fired_in = fired_ff;
               rsp_idx_in   = idx_ff;
               rsp_ticks_in = idx_ok ? oectmr_pkg::VALUE_WIDTH'(exec_wd[TICK_WIDTH-1:0]) : '0;
               rsp_run_in   = idx_ok && exec_wd[RUN_BIT];
               rsp_fin_in   = idx_ok && exec_wd[FIN_BIT];
               state_in     = oectmr_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = oectmr_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= oectmr_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         loop_ff      <= '0;
         rem_ff       <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= '0;
         inrem_ff     <= 1'b0;
         wr_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= '0;
      end else begin
         if (csr_we) begin
            case (oectmr_pkg::csr_index_type'(csr_index))
               oectmr_pkg::CSR_LOOP_COUNT: begin
                  loop_ff <= csr_wdata;
               end
               oectmr_pkg::CSR_REMAINDER_COUNT: begin
                  rem_ff <= csr_wdata[oectmr_pkg::CNT_WIDTH-1:0];
               end
               default: begin
                  rem_ff <= rem_ff;
               end
            endcase
         end
         if (state_ff == oectmr_pkg::S_IDLE && req_chan.valid) begin
            cnt_ff   <= cnt_in;
            ovf_ff   <= ovf_in;
            inrem_ff <= inrem_in;
         end
         wr_pend_ff   <= wr_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) begin
            vld_ff[mem_wa] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff       <= cmd_in;
      idx_ff       <= idx_in;
      val_ff       <= val_in;
      fired_ff     <= fired_in;
      ptr_ff       <= ptr_in;
      wr_addr_ff   <= wr_addr_in;
      rsp_fired_ff <= rsp_fired_in;
      rsp_idx_ff   <= rsp_idx_in;
      rsp_ticks_ff <= rsp_ticks_in;
      rsp_run_ff   <= rsp_run_in;
      rsp_fin_ff   <= rsp_fin_in;
   end

   // slot ram: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      if (mem_re) begin
         rd_data_ff <= mem[mem_ra];
         rd_vld_ff  <= vld_ff[mem_ra];
      end
   end

   a_no_rw_collision : assert property (@(posedge clock) disable iff (reset)
      !(mem_we && mem_re && (mem_wa == mem_ra)))
      else $error("slot ram read and write hit the same entry");

   a_fire_sweeps : assert property (@(posedge clock) disable iff (reset)
      (req_chan.valid && req_chan.ready && fire) |=> (state_ff == oectmr_pkg::S_SWEEP))
      else $error("base tick did not start a sweep");

   a_exec_delivers : assert property (@(posedge clock) disable iff (reset)
      (state_ff == oectmr_pkg::S_EXEC && done) |=> rsp_valid_ff)
      else $error("finished item produced no result");

   a_sweep_blocks : assert property (@(posedge clock) disable iff (reset)
      (state_ff == oectmr_pkg::S_SWEEP) |=>
         (state_ff == oectmr_pkg::S_SWEEP || state_ff == oectmr_pkg::S_DRAIN))
      else $error("sweep left early");

endmodule : overflow_extended_countdown_timers_core
`default_nettype wire

// File: tb/overflow_extended_countdown_timers_core_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// overflow_extended_countdown_timers_core_test
// Self-checking bench for the prescaled countdown timer bank. A short directed table
// is followed by random command phases over several prescaler settings. Each status
// item is checked against its typed table row or a behavioral model of the bank.
// ----------------------------------------------------------------------------
module overflow_extended_countdown_timers_core_test;

   localparam int SLOTS          = 16;
   localparam int CYCLE_LIMIT    = 200000;
   localparam int DRAIN_CYCLES   = 40;
   localparam int HOLD_AT_RESULT = 310;
   localparam int HOLD_CYCLES    = 80;
   localparam int PAUSE_AT_ITEM  = 455;
   localparam int QUIET_FIRST    = 380;
   localparam int QUIET_LAST     = 440;
   localparam int REPORT_LIMIT   = 10;

   typedef struct packed {
      oectmr_pkg::cmd_type                 cmd;
      logic [oectmr_pkg::INDEX_WIDTH-1:0]  slot;
      logic [oectmr_pkg::VALUE_WIDTH-1:0]  value;
   } timer_cmd_type;

   typedef struct packed {
      logic                                tick;
      logic [oectmr_pkg::INDEX_WIDTH-1:0]  slot;
      logic [oectmr_pkg::VALUE_WIDTH-1:0]  ticks;
      logic                                running;
      logic                                done;
   } timer_status_type;

   typedef struct packed {
      timer_cmd_type     item;
      logic [8:0]        copies;
      logic              typed;
      timer_status_type  status;
   } directed_row_type;

   typedef struct packed {
      logic [oectmr_pkg::LOOP_WIDTH-1:0]  loop;
      logic [oectmr_pkg::CNT_WIDTH-1:0]   rem;
      logic [9:0]                         items;
      logic [6:0]                         pulse_pct;
      logic                               restarts;
   } phase_type;

   // runs from reset values: loop_count 0, remainder_count 0
   localparam directed_row_type DIRECTED [26] = '{
      '{'{oectmr_pkg::CMD_READ, 4'd0, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd0, 32'h0, 1'b0, 1'b0}},
      // unused command behaves as a read
      '{'{oectmr_pkg::CMD_RSVD, 4'd15, 32'hffff_ffff}, 9'd1, 1'b1,
        '{1'b0, 4'd15, 32'h0, 1'b0, 1'b0}},
      // from reset the first overflow only enters the remainder phase
      '{'{oectmr_pkg::CMD_COUNT, 4'd3, 32'h0}, 9'd255, 1'b0, '0},
      '{'{oectmr_pkg::CMD_COUNT, 4'd3, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd3, 32'h0, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_COUNT, 4'd3, 32'h0}, 9'd1, 1'b1,
        '{1'b1, 4'd3, 32'h0, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_LOAD, 4'd15, 32'hffff_ffff}, 9'd1, 1'b1,
        '{1'b0, 4'd15, 32'hffff_ffff, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_LOAD, 4'd0, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd0, 32'h0, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_LOAD, 4'd1, 32'h1}, 9'd1, 1'b1,
        '{1'b0, 4'd1, 32'h1, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_LOAD, 4'd2, 32'h2}, 9'd1, 1'b1,
        '{1'b0, 4'd2, 32'h2, 1'b0, 1'b0}},
      // slot 0 runs at zero and wraps on the next tick
      '{'{oectmr_pkg::CMD_START, 4'd0, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd0, 32'h0, 1'b1, 1'b0}},
      '{'{oectmr_pkg::CMD_START, 4'd1, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd1, 32'h1, 1'b1, 1'b0}},
      '{'{oectmr_pkg::CMD_START, 4'd2, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd2, 32'h2, 1'b1, 1'b0}},
      '{'{oectmr_pkg::CMD_START, 4'd15, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd15, 32'hffff_ffff, 1'b1, 1'b0}},
      '{'{oectmr_pkg::CMD_COUNT, 4'd1, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_COUNT, 4'd0, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_COUNT, 4'd2, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_STOP, 4'd15, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_COUNT, 4'd15, 32'h0}, 9'd1, 1'b0, '0},
      // restart of a finished slot at zero
      '{'{oectmr_pkg::CMD_START, 4'd1, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_COUNT, 4'd1, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_RESTART, 4'd7, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd7, 32'h0, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_COUNT, 4'd0, 32'h0}, 9'd1, 1'b0, '0},
      '{'{oectmr_pkg::CMD_CLEAR, 4'd0, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd0, 32'h0, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_CLEAR, 4'd15, 32'h0}, 9'd1, 1'b1,
        '{1'b0, 4'd15, 32'h0, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_LOAD, 4'd9, 32'ha5a5_5a5a}, 9'd1, 1'b1,
        '{1'b0, 4'd9, 32'ha5a5_5a5a, 1'b0, 1'b0}},
      '{'{oectmr_pkg::CMD_READ, 4'd2, 32'h0}, 9'd1, 1'b0, '0}
   };

   // the loop_count 2 phase leaves the overflow count above the lowered setting
   localparam phase_type PHASES [5] = '{
      '{16'd0,     8'd0,   10'd60,  7'd40, 1'b1},
      '{16'd0,     8'd2,   10'd50,  7'd50, 1'b1},
      '{16'd2,     8'd7,   10'd50,  7'd95, 1'b0},
      '{16'd0,     8'd5,   10'd30,  7'd60, 1'b0},
      '{16'hffff,  8'hff,  10'd30,  7'd40, 1'b1}
   };

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic                              csr_index;
   logic [oectmr_pkg::CSR_WIDTH-1:0]  csr_wdata;

   oectmr_req_if req_bus ();
   oectmr_rsp_if rsp_bus ();

   overflow_extended_countdown_timers_core DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_bus),
      .rsp_chan  (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // model of the prescaler and the timer bank
   logic [oectmr_pkg::CNT_WIDTH-1:0]    prescaler;
   logic [oectmr_pkg::LOOP_WIDTH-1:0]   overflow_cnt;
   logic                                remainder_phase;
   logic [oectmr_pkg::LOOP_WIDTH-1:0]   cfg_loop;
   logic [oectmr_pkg::CNT_WIDTH-1:0]    cfg_remainder;
   logic [oectmr_pkg::VALUE_WIDTH-1:0]  timer_ticks [SLOTS];
   logic                                timer_running [SLOTS];
   logic                                timer_done [SLOTS];

   timer_status_type  status_queue [$];
   int                items_sent;
   int                results_seen;
   int                ticks_seen;
   int                mismatches;
   int                cycle_count;
   int                hold_left;
   bit                hold_done;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit quiet_stretch();
      return items_sent >= QUIET_FIRST && items_sent < QUIET_LAST;
   endfunction

   function automatic void restart_period();
      if (cfg_loop != '0) begin
         overflow_cnt = '0;
         remainder_phase = 1'b0;
      end else begin
         remainder_phase = 1'b1;
         prescaler = oectmr_pkg::CNT_TOP - cfg_remainder;
      end
   endfunction

   function automatic timer_status_type apply_command(input timer_cmd_type item);
      timer_status_type status;
      status = '0;
      case (item.cmd)
         oectmr_pkg::CMD_COUNT: begin
            prescaler = prescaler + 1'b1;
            if (prescaler == '0) begin
               if (overflow_cnt != cfg_loop) begin
                  overflow_cnt = overflow_cnt + 1'b1;
               end else if (!remainder_phase) begin
                  remainder_phase = 1'b1;
                  prescaler = oectmr_pkg::CNT_TOP - cfg_remainder;
               end else begin
                  status.tick = 1'b1;
                  for (int s = 0; s < SLOTS; s++) begin
                     if (timer_running[s]) begin
                        timer_ticks[s] = timer_ticks[s] - 1'b1;
                        if (timer_ticks[s] == '0) begin
                           timer_running[s] = 1'b0;
                           timer_done[s] = 1'b1;
                        end
                     end
                  end
                  restart_period();
               end
            end
         end
         oectmr_pkg::CMD_LOAD: begin
            timer_ticks[item.slot] = item.value;
         end
         oectmr_pkg::CMD_START: begin
            timer_running[item.slot] = 1'b1;
            timer_done[item.slot] = 1'b0;
         end
         oectmr_pkg::CMD_STOP: begin
            timer_running[item.slot] = 1'b0;
         end
         oectmr_pkg::CMD_CLEAR: begin
            timer_ticks[item.slot] = '0;
            timer_running[item.slot] = 1'b0;
            timer_done[item.slot] = 1'b0;
         end
         oectmr_pkg::CMD_RESTART: begin
            restart_period();
         end
         default: begin
         end
      endcase
      status.slot = item.slot;
      status.ticks = timer_ticks[item.slot];
      status.running = timer_running[item.slot];
      status.done = timer_done[item.slot];
      return status;
   endfunction

   task automatic offer_item(input timer_cmd_type item, input logic typed,
                             input timer_status_type typed_status);
      timer_status_type predicted;
      while (!quiet_stretch() && $urandom_range(99) < 14) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.cmd <= item.cmd;
      req_bus.timer_index <= item.slot;
      req_bus.load_value <= item.value;
      do @(posedge clock); while (!req_bus.ready);
      predicted = apply_command(item);
      status_queue.push_back(typed ? typed_status : predicted);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_bus.valid <= 1'b0;
      while (status_queue.size() != 0) @(posedge clock);
   endtask

   task automatic program_timing(input logic [oectmr_pkg::LOOP_WIDTH-1:0] loop,
                                 input logic [oectmr_pkg::CNT_WIDTH-1:0] rem);
      csr_we <= 1'b1;
      csr_index <= oectmr_pkg::CSR_LOOP_COUNT;
      csr_wdata <= loop;
      @(posedge clock);
      // upper bits beyond the 8-bit register are junk and must be dropped
      csr_index <= oectmr_pkg::CSR_REMAINDER_COUNT;
      csr_wdata <= {8'($urandom_range(255)), rem};
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_loop = loop;
      cfg_remainder = rem;
   endtask

   // result side: check each item and drive ready
   always @(posedge clock) begin
      timer_status_type seen;
      timer_status_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen = '{rsp_bus.tick_fired, rsp_bus.slot_index, rsp_bus.ticks_left,
                  rsp_bus.slot_running, rsp_bus.slot_finished};
         results_seen++;
         if (seen.tick) ticks_seen++;
         if (status_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
               $display("status item with nothing expected: slot %0d ticks %h", seen.slot,
                        seen.ticks);
         end else begin
            want = status_queue.pop_front();
            if (seen.tick !== want.tick || seen.slot !== want.slot ||
                seen.ticks !== want.ticks || seen.running !== want.running ||
                seen.done !== want.done) begin
               mismatches++;
               if (mismatches <= REPORT_LIMIT)
                  $display("result %0d: expected tick %0b slot %0d ticks %h run %0b done %0b, %s",
                           results_seen, want.tick, want.slot, want.ticks, want.running,
                           want.done, $sformatf("got tick %0b slot %0d ticks %h run %0b done %0b",
                           seen.tick, seen.slot, seen.ticks, seen.running, seen.done));
            end
         end
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         // one long hold-off so the block backs up into its input
         if (results_seen == HOLD_AT_RESULT && !hold_done) begin
            hold_left = HOLD_CYCLES;
            hold_done = 1'b1;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= quiet_stretch() || ($urandom_range(99) >= 14);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d items still expected", cycle_count,
                  status_queue.size());
         $display("overflow_extended_countdown_timers_core regression: fail");
         $finish;
      end
   end

   initial begin
      timer_cmd_type item;
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.cmd = oectmr_pkg::CMD_READ;
      req_bus.timer_index = '0;
      req_bus.load_value = '0;
      rsp_bus.ready = 1'b0;
      csr_we = 1'b0;
      csr_index = oectmr_pkg::CSR_LOOP_COUNT;
      csr_wdata = '0;
      prescaler = '0;
      overflow_cnt = '0;
      remainder_phase = 1'b0;
      cfg_loop = '0;
      cfg_remainder = '0;
      foreach (timer_ticks[s]) begin
         timer_ticks[s] = '0;
         timer_running[s] = 1'b0;
         timer_done[s] = 1'b0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[r])
         repeat (DIRECTED[r].copies)
            offer_item(DIRECTED[r].item, DIRECTED[r].typed, DIRECTED[r].status);

      foreach (PHASES[p]) begin
         wait_for_results();
         program_timing(PHASES[p].loop, PHASES[p].rem);
         repeat (PHASES[p].items) begin
            if (items_sent == PAUSE_AT_ITEM) wait_for_results();
            item.cmd = ($urandom_range(99) < PHASES[p].pulse_pct) ? oectmr_pkg::CMD_COUNT :
                       oectmr_pkg::cmd_type'($urandom_range(1, 7));
            if (item.cmd == oectmr_pkg::CMD_RESTART && !PHASES[p].restarts)
               item.cmd = oectmr_pkg::CMD_READ;
            item.slot = oectmr_pkg::INDEX_WIDTH'($urandom_range(SLOTS - 1));
            case ($urandom_range(9)) inside
               [0:3]:   item.value = oectmr_pkg::VALUE_WIDTH'($urandom_range(1, 6));
               4:       item.value = '0;
               5:       item.value = '1;
               default: item.value = $urandom();
            endcase
            offer_item(item, 1'b0, '0);
         end
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("%0d command items over %0d prescaler settings, %0d status items checked",
               items_sent, $size(PHASES) + 1, results_seen);
      $display("%0d base ticks seen, %0d mismatches", ticks_seen, mismatches);
      if (mismatches == 0 && status_queue.size() == 0) begin
         $display("overflow_extended_countdown_timers_core regression: pass");
      end else begin
         $display("overflow_extended_countdown_timers_core regression: fail");
      end
      $finish;
   end

endmodule : overflow_extended_countdown_timers_core_test
